// ===== sv/cmae_pkg.sv =====
// Shared constants, types and fixed-point helpers of the complex matrix engine.
// No dependencies; every other file imports this package.
package cmae_pkg;

   localparam int DIM_MAX = 8;
   localparam int IDX_W   = 3;
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int PART_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 2 * PART_W;
   // Room for 2 * DIM_MAX products of PROD_W bits.
   localparam int ACC_W   = PROD_W + 4;
   localparam int SAT_W   = ACC_W - FRAC_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_POW = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 3'd5;

   localparam logic signed [PART_W-1:0] ONE_FIX = PART_W'(1) << FRAC_W;

   typedef struct packed {
      logic clear;
      logic valid;
      logic neg;
      logic to_im;
   } mac_ctrl_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [PART_W-1:0] value;
   } sat_type;

   function automatic logic dim_ok(input logic [3:0] d);
      return (d != 4'd0) && (d <= 4'(DIM_MAX));
   endfunction

   // Saturate a wide signed value to PART_W bits.
   function automatic sat_type sat_part(input logic signed [SAT_W-1:0] v);
      sat_type r;
      logic    fits;
      fits = (&v[SAT_W-1:PART_W-1]) || !(|v[SAT_W-1:PART_W-1]);
      r.ovf = !fits;
      if (fits) begin
         r.value = v[PART_W-1:0];
      end else begin
         r.value = v[SAT_W-1] ? {1'b1, {(PART_W-1){1'b0}}} : {1'b0, {(PART_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Round half up to FRAC_W fraction bits, then saturate.
   function automatic sat_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sum;
      sum = acc + (ACC_W'(1) <<< (FRAC_W - 1));
      return sat_part(sum[ACC_W-1:FRAC_W]);
   endfunction

endpackage

// ===== sv/cmae_req_if.sv =====
// Input channel of the complex matrix engine: load and start commands.
// Depends on cmae_pkg.
interface cmae_req_if;
   import cmae_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic [IDX_W-1:0]         row;
   logic [IDX_W-1:0]         col;
   logic signed [PART_W-1:0] value_re;
   logic signed [PART_W-1:0] value_im;
   modport source (output valid, command, row, col, value_re, value_im, input ready);
   modport sink (input valid, command, row, col, value_re, value_im, output ready);
endinterface

// ===== sv/cmae_rsp_if.sv =====
// Result channel of the complex matrix engine: one matrix element per item.
// Depends on cmae_pkg.
interface cmae_rsp_if;
   import cmae_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic signed [PART_W-1:0] result_re;
   logic signed [PART_W-1:0] result_im;
   logic                     size_error;
   logic                     overflow;
   logic                     last;
   modport source (output valid, out_row, out_col, result_re, result_im, size_error,
                   overflow, last, input ready);
   modport sink (input valid, out_row, out_col, result_re, result_im, size_error,
                 overflow, last, output ready);
endinterface

// ===== sv/cmae_csr_if.sv =====
// Configuration write channel of the complex matrix engine.
// Depends on cmae_pkg.
interface cmae_csr_if;
   import cmae_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/cmae_mac.sv =====
// Shared complex multiply-accumulate unit: one signed multiplier, two accumulators.
// Depends on cmae_pkg.
module cmae_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  cmae_pkg::mac_ctrl_type            ctrl,
   input  logic signed [cmae_pkg::PART_W-1:0] op_x,
   input  logic signed [cmae_pkg::PART_W-1:0] op_y,
   output logic signed [cmae_pkg::PART_W-1:0] res_re,
   output logic signed [cmae_pkg::PART_W-1:0] res_im,
   output logic                              res_ovf
);
   import cmae_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     pv_ff, pneg_ff, pim_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;
   logic signed [ACC_W-1:0]  addend;
   sat_type                  sat_re, sat_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctrl.valid;
      end
      prod_ff <= op_x * op_y;
      pneg_ff <= ctrl.neg;
      pim_ff  <= ctrl.to_im;
   end

   assign addend = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (pv_ff) begin
         if (pim_ff) begin
            acc_im_ff <= pneg_ff ? acc_im_ff - addend : acc_im_ff + addend;
         end else begin
            acc_re_ff <= pneg_ff ? acc_re_ff - addend : acc_re_ff + addend;
         end
      end
   end

   assign sat_re  = round_sat(acc_re_ff);
   assign sat_im  = round_sat(acc_im_ff);
   assign res_re  = sat_re.value;
   assign res_im  = sat_im.value;
   assign res_ovf = sat_re.ovf | sat_im.ovf;

endmodule

// ===== sv/complex_matrix_arith_engine_core.sv =====
// Complex matrix engine top level: operand stores, sequencer and result register.
// Depends on cmae_pkg, the three channel interfaces and cmae_mac.
//
//   channel | direction | handshake     | moves
//   req_ch  | in        | valid / ready | load A element, load B element, start
//   rsp_ch  | out       | valid / ready | one result element, row-major, last marker
//   csr_ch  | in        | valid / ready | register index and write data
//
// A start item occupies the block until the last result item has been loaded into the
// output register; req_ch.ready is low meanwhile. Add, subtract, identity and plain copy
// step through fetch, calc and emit per element. Multiply steps through fetch and the four
// partial products of a complex product in turn for each inner index, then drain, finish
// and emit per element, all on one 32x32 multiplier; power repeats that sweep n-1 times.
// Reset is synchronous and clears control state only; the stores hold no reset value.
// A stall on rsp_ch holds the sequencer in its emit step; csr_ch is always ready.
module complex_matrix_arith_engine_core (
   input  logic      clock,
   input  logic      reset,
   cmae_req_if.sink  req_ch,
   cmae_rsp_if.source rsp_ch,
   cmae_csr_if.sink  csr_ch
);
   import cmae_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_CALC   = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   // Kind of run chosen at start.
   localparam logic [2:0] K_ADD   = 3'd0;
   localparam logic [2:0] K_SUB   = 3'd1;
   localparam logic [2:0] K_MUL   = 3'd2;
   localparam logic [2:0] K_IDENT = 3'd3;
   localparam logic [2:0] K_COPY  = 3'd4;
   localparam logic [2:0] K_POW   = 3'd5;
   localparam logic [2:0] K_ERR   = 3'd6;

   // Configuration registers.
   logic [1:0] op_mode_ff;
   logic [3:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [7:0] exponent_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff  <= MODE_ADD;
         rows_a_ff   <= 4'd1;
         cols_a_ff   <= 4'd1;
         rows_b_ff   <= 4'd1;
         cols_b_ff   <= 4'd1;
         exponent_ff <= 8'd0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_OP_MODE:  op_mode_ff  <= csr_ch.data[1:0];
            CSR_ROWS_A:   rows_a_ff   <= csr_ch.data[3:0];
            CSR_COLS_A:   cols_a_ff   <= csr_ch.data[3:0];
            CSR_ROWS_B:   rows_b_ff   <= csr_ch.data[3:0];
            CSR_COLS_B:   cols_b_ff   <= csr_ch.data[3:0];
            CSR_EXPONENT: exponent_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Sequencer registers.
   logic [2:0]       state_ff, state_in;
   logic [2:0]       kind_ff, kind_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0] rmax_ff, rmax_in, cmax_ff, cmax_in, kmax_ff, kmax_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       step_ff, step_in;
   logic             bank_ff, bank_in;

   // Start decode: shape check and the kind of run.
   logic       start_ok;
   logic [2:0] start_kind;
   logic [3:0] start_cols, start_inner;

   always_comb begin
      start_cols  = cols_a_ff;
      start_inner = cols_a_ff;
      case (op_mode_ff)
         MODE_ADD, MODE_SUB: begin
            start_ok = dim_ok(rows_a_ff) && dim_ok(cols_a_ff) &&
                       rows_a_ff == rows_b_ff && cols_a_ff == cols_b_ff;
            start_kind = (op_mode_ff == MODE_SUB) ? K_SUB : K_ADD;
         end
         MODE_MUL: begin
            start_ok = dim_ok(rows_a_ff) && dim_ok(cols_a_ff) && dim_ok(cols_b_ff) &&
                       cols_a_ff == rows_b_ff;
            start_cols = cols_b_ff;
            start_kind = K_MUL;
         end
         default: begin
            start_ok    = dim_ok(rows_a_ff) && rows_a_ff == cols_a_ff;
            start_cols  = rows_a_ff;
            start_inner = rows_a_ff;
            if (exponent_ff == 8'd0) begin
               start_kind = K_IDENT;
            end else if (exponent_ff == 8'd1) begin
               start_kind = K_COPY;
            end else begin
               start_kind = K_POW;
            end
         end
      endcase
   end

   logic req_fire, start_fire, load_a, load_b;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire   = req_ch.valid && req_ch.ready;
   assign start_fire = req_fire && req_ch.command == CMD_START;
   assign load_a     = req_fire && req_ch.command == CMD_LOAD_A;
   assign load_b     = req_fire && req_ch.command == CMD_LOAD_B;

   // Stores. The work store holds two banks of the running power product.
   logic [2*PART_W-1:0] a_mem [2**ADDR_W];
   logic [2*PART_W-1:0] b_mem [2**ADDR_W];
   logic [2*PART_W-1:0] w_mem [2**(ADDR_W+1)];
   logic [2*PART_W-1:0] al_rd_ff, ar_rd_ff, b_rd_ff, w_rd_ff;
   logic [ADDR_W-1:0]   ld_addr, l_addr, r_addr, ij_addr;
   logic                rd_en, use_k, w_we;
   logic [2*PART_W-1:0] ld_data;

   // Result of the current element before it enters the output register.
   logic signed [PART_W-1:0] res_re_ff, res_im_ff;
   logic                     res_ov_ff, res_err_ff;

   logic signed [PART_W-1:0] mac_re, mac_im;
   logic                     mac_ovf;

   assign ld_addr = {req_ch.row, req_ch.col};
   assign ld_data = {req_ch.value_re, req_ch.value_im};
   assign use_k   = (kind_ff == K_MUL) || (kind_ff == K_POW);
   assign ij_addr = {i_ff, j_ff};
   assign l_addr  = use_k ? {i_ff, k_ff} : ij_addr;
   assign r_addr  = use_k ? {k_ff, j_ff} : ij_addr;
   assign rd_en   = (state_ff == S_FETCH);

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_mem[ld_addr] <= ld_data;
      end
      if (rd_en) begin
         al_rd_ff <= a_mem[l_addr];
         ar_rd_ff <= a_mem[r_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         b_mem[ld_addr] <= ld_data;
      end
      if (rd_en) begin
         b_rd_ff <= b_mem[r_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[{~bank_ff, ij_addr}] <= {mac_re, mac_im};
      end
      if (rd_en) begin
         w_rd_ff <= w_mem[{bank_ff, l_addr}];
      end
   end

   // Operand selection. The first power step multiplies A by A; later steps take the
   // left operand from the bank written by the step before.
   logic signed [PART_W-1:0] l_re, l_im, r_re, r_im;
   logic                     left_from_w;

   assign left_from_w = (kind_ff == K_POW) && (step_ff != 8'd1);
   assign l_re = left_from_w ? w_rd_ff[2*PART_W-1:PART_W] : al_rd_ff[2*PART_W-1:PART_W];
   assign l_im = left_from_w ? w_rd_ff[PART_W-1:0] : al_rd_ff[PART_W-1:0];
   assign r_re = (kind_ff == K_POW) ? ar_rd_ff[2*PART_W-1:PART_W] : b_rd_ff[2*PART_W-1:PART_W];
   assign r_im = (kind_ff == K_POW) ? ar_rd_ff[PART_W-1:0] : b_rd_ff[PART_W-1:0];

   // Four phases per inner index: re*re, -im*im into the real sum; re*im, im*re into
   // the imaginary sum.
   mac_ctrl_type             mac_ctrl;
   logic signed [PART_W-1:0] op_x, op_y;

   always_comb begin
      mac_ctrl.clear = start_fire || (state_ff == S_FINISH);
      mac_ctrl.valid = (state_ff == S_MUL);
      mac_ctrl.neg   = (phase_ff == 2'd1);
      mac_ctrl.to_im = phase_ff[1];
      case (phase_ff)
         2'd0: begin op_x = l_re; op_y = r_re; end
         2'd1: begin op_x = l_im; op_y = r_im; end
         2'd2: begin op_x = l_re; op_y = r_im; end
         default: begin op_x = l_im; op_y = r_re; end
      endcase
   end

   cmae_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .op_x    (op_x),
      .op_y    (op_y),
      .res_re  (mac_re),
      .res_im  (mac_im),
      .res_ovf (mac_ovf)
   );

   // Per-element overflow history across the steps of a power run.
   logic [2**ADDR_W-1:0] ovf_ff;

   logic last_elem, pow_final, emit_go;
   assign last_elem = (i_ff == rmax_ff) && (j_ff == cmax_ff);
   assign pow_final = (step_ff == exponent_ff - 8'd1);
   assign w_we      = (state_ff == S_FINISH) && (kind_ff == K_POW) && !pow_final;

   logic rsp_valid_ff;
   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      rmax_in  = rmax_ff;
      cmax_in  = cmax_ff;
      kmax_in  = kmax_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      bank_in  = bank_ff;
      case (state_ff)
         S_IDLE: begin
            if (start_fire) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               phase_in = '0;
               step_in  = 8'd1;
               bank_in  = 1'b0;
               if (start_ok) begin
                  kind_in  = start_kind;
                  rmax_in  = IDX_W'(rows_a_ff - 4'd1);
                  cmax_in  = IDX_W'(start_cols - 4'd1);
                  kmax_in  = IDX_W'(start_inner - 4'd1);
                  state_in = S_FETCH;
               end else begin
                  kind_in  = K_ERR;
                  rmax_in  = '0;
                  cmax_in  = '0;
                  kmax_in  = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_FETCH: begin
            state_in = use_k ? S_MUL : S_CALC;
         end
         S_MUL: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (k_ff == kmax_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (w_we) begin
               k_in     = '0;
               state_in = S_FETCH;
               if (last_elem) begin
                  i_in    = '0;
                  j_in    = '0;
                  step_in = step_ff + 8'd1;
                  bank_in = ~bank_ff;
               end else if (j_ff == cmax_ff) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               state_in = S_EMIT;
            end
         end
         S_CALC: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_go) begin
               k_in = '0;
               if (last_elem) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FETCH;
                  if (j_ff == cmax_ff) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= K_ADD;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         rmax_ff  <= '0;
         cmax_ff  <= '0;
         kmax_ff  <= '0;
         phase_ff <= '0;
         step_ff  <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         rmax_ff  <= rmax_in;
         cmax_ff  <= cmax_in;
         kmax_ff  <= kmax_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start_fire) begin
         ovf_ff <= '0;
      end else if (w_we) begin
         ovf_ff[ij_addr] <= ovf_ff[ij_addr] | mac_ovf;
      end
   end

   // Element results: the elementwise kinds are worked out here, products come from
   // the accumulator once it has drained.
   logic signed [SAT_W-1:0] sum_wide;
   sat_type                 sum_sat;

   always_comb begin
      if (kind_ff == K_SUB) begin
         sum_wide = SAT_W'(l_re) - SAT_W'(r_re);
      end else begin
         sum_wide = SAT_W'(l_re) + SAT_W'(r_re);
      end
   end
   assign sum_sat = sat_part(sum_wide);

   logic signed [SAT_W-1:0] sum_wide_im;
   sat_type                 sum_sat_im;

   always_comb begin
      if (kind_ff == K_SUB) begin
         sum_wide_im = SAT_W'(l_im) - SAT_W'(r_im);
      end else begin
         sum_wide_im = SAT_W'(l_im) + SAT_W'(r_im);
      end
   end
   assign sum_sat_im = sat_part(sum_wide_im);

   always_ff @(posedge clock) begin
      if (start_fire && !start_ok) begin
         res_re_ff  <= '0;
         res_im_ff  <= '0;
         res_ov_ff  <= 1'b0;
         res_err_ff <= 1'b1;
      end else if (state_ff == S_FINISH) begin
         res_re_ff  <= mac_re;
         res_im_ff  <= mac_im;
         res_ov_ff  <= mac_ovf | ((kind_ff == K_POW) & ovf_ff[ij_addr]);
         res_err_ff <= 1'b0;
      end else if (state_ff == S_CALC) begin
         res_err_ff <= 1'b0;
         case (kind_ff)
            K_ADD, K_SUB: begin
               res_re_ff <= sum_sat.value;
               res_im_ff <= sum_sat_im.value;
               res_ov_ff <= sum_sat.ovf | sum_sat_im.ovf;
            end
            K_IDENT: begin
               res_re_ff <= (i_ff == j_ff) ? ONE_FIX : '0;
               res_im_ff <= '0;
               res_ov_ff <= 1'b0;
            end
            default: begin
               res_re_ff <= l_re;
               res_im_ff <= l_im;
               res_ov_ff <= 1'b0;
            end
         endcase
      end
   end

   // Output register: one item waits here while the sequencer moves on.
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [PART_W-1:0] rsp_re_ff, rsp_im_ff;
   logic                     rsp_err_ff, rsp_ov_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_row_ff  <= i_ff;
         rsp_col_ff  <= j_ff;
         rsp_re_ff   <= res_re_ff;
         rsp_im_ff   <= res_im_ff;
         rsp_err_ff  <= res_err_ff;
         rsp_ov_ff   <= res_ov_ff;
         rsp_last_ff <= last_elem;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_row    = rsp_row_ff;
   assign rsp_ch.out_col    = rsp_col_ff;
   assign rsp_ch.result_re  = rsp_re_ff;
   assign rsp_ch.result_im  = rsp_im_ff;
   assign rsp_ch.size_error = rsp_err_ff;
   assign rsp_ch.overflow   = rsp_ov_ff;
   assign rsp_ch.last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_inner_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> k_ff <= kmax_ff)
      else $error("inner index ran past its bound");
   a_phase_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && phase_ff == 2'd3) |=> (state_ff == S_FETCH || state_ff == S_DRAIN))
      else $error("multiply phases did not close the inner step");
   a_pow_steps: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == K_POW && state_ff != S_IDLE) |-> step_ff < exponent_ff)
      else $error("power step count overran the exponent");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.size_error) |-> rsp_ch.last)
      else $error("size error item without last marker");
`endif

endmodule

// ===== tb/cmae_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the complex matrix engine: watches the three channels, predicts results.
// Depends on cmae_pkg and the req, rsp and csr channel interfaces.
module cmae_checker (
   input  logic clock,
   input  logic reset,
   cmae_req_if  req,
   cmae_rsp_if  rsp,
   cmae_csr_if  csr,
   output int   fail_count,
   output int   pending,
   output int   result_count,
   output int   start_count
);
   import cmae_pkg::*;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] re;
      logic [31:0] im;
      logic        err;
      logic        ovf;
      logic        last;
   } elem_type;

   elem_type   due_elems[$];
   longint     a_re[64], a_im[64], b_re[64], b_im[64];
   longint     w_re[64], w_im[64], n_re[64], n_im[64];
   bit         ovf_flag[64];
   logic [1:0] mode;
   logic [3:0] ra, ca, rb, cb;
   logic [7:0] power;

   function automatic longint clamp(longint v, inout bit ov);
      if (v > 64'sd2147483647) begin
         ov = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ov = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic bit dim_good(logic [3:0] d);
      return d >= 1 && d <= 8;
   endfunction

   // n = x * y with each element rounded half up and saturated.
   function automatic void mul_pass(bit x_work, bit y_is_a, int rows, int inner, int cols);
      longint hr, lr, hi, li, p, xr, xi, yr, yi;
      bit     ov;
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            hr = 0; lr = 0; hi = 0; li = 0; ov = 0;
            for (int k = 0; k < inner; k++) begin
               xr = x_work ? w_re[i*8+k] : a_re[i*8+k];
               xi = x_work ? w_im[i*8+k] : a_im[i*8+k];
               yr = y_is_a ? a_re[k*8+j] : b_re[k*8+j];
               yi = y_is_a ? a_im[k*8+j] : b_im[k*8+j];
               p = xr * yr;     hr += p >>> 16; lr += p & 64'hFFFF;
               p = -(xi * yi);  hr += p >>> 16; lr += p & 64'hFFFF;
               p = xr * yi;     hi += p >>> 16; li += p & 64'hFFFF;
               p = xi * yr;     hi += p >>> 16; li += p & 64'hFFFF;
            end
            hr += (lr + 32768) >>> 16;
            hi += (li + 32768) >>> 16;
            n_re[i*8+j] = clamp(hr, ov);
            n_im[i*8+j] = clamp(hi, ov);
            if (ov) ovf_flag[i*8+j] = 1;
         end
      end
   endfunction

   function automatic void predict_run();
      int       rows, cols, ix;
      bit       ok, ov;
      longint   br, bi;
      elem_type e;
      foreach (ovf_flag[i]) ovf_flag[i] = 0;
      if (mode == MODE_ADD || mode == MODE_SUB) begin
         ok = dim_good(ra) && dim_good(ca) && ra == rb && ca == cb;
         rows = ra; cols = ca;
      end else if (mode == MODE_MUL) begin
         ok = dim_good(ra) && dim_good(ca) && dim_good(cb) && ca == rb;
         rows = ra; cols = cb;
      end else begin
         ok = dim_good(ra) && ra == ca;
         rows = ra; cols = ra;
      end
      if (!ok) begin
         e = '{row: 0, col: 0, re: 0, im: 0, err: 1, ovf: 0, last: 1};
         due_elems.insert(due_elems.size(), e);
         return;
      end
      if (mode == MODE_ADD || mode == MODE_SUB) begin
         for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
               ix = i*8+j; ov = 0;
               br = (mode == MODE_SUB) ? -b_re[ix] : b_re[ix];
               bi = (mode == MODE_SUB) ? -b_im[ix] : b_im[ix];
               w_re[ix] = clamp(a_re[ix] + br, ov);
               w_im[ix] = clamp(a_im[ix] + bi, ov);
               ovf_flag[ix] = ov;
            end
         end
      end else if (mode == MODE_MUL) begin
         mul_pass(0, 0, rows, int'(ca), cols);
         w_re = n_re; w_im = n_im;
      end else if (power == 0) begin
         for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
               w_re[i*8+j] = (i == j) ? 64'sd65536 : 0;
               w_im[i*8+j] = 0;
            end
         end
      end else begin
         w_re = a_re; w_im = a_im;
         for (int c = 1; c < power; c++) begin
            mul_pass(1, 1, rows, rows, rows);
            w_re = n_re; w_im = n_im;
         end
      end
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            e.row = 3'(i); e.col = 3'(j);
            e.re = w_re[i*8+j][31:0];
            e.im = w_im[i*8+j][31:0];
            e.err = 0;
            e.ovf = ovf_flag[i*8+j];
            e.last = (i == rows-1) && (j == cols-1);
            due_elems.insert(due_elems.size(), e);
         end
      end
   endfunction

   assign pending = due_elems.size();

   always @(posedge clock) begin
      elem_type want;
      if (reset) begin
         mode <= MODE_ADD; ra <= 1; ca <= 1; rb <= 1; cb <= 1; power <= 0;
         fail_count = 0; result_count = 0; start_count = 0;
         foreach (a_re[i]) begin
            a_re[i] = 0; a_im[i] = 0; b_re[i] = 0; b_im[i] = 0;
            w_re[i] = 0; w_im[i] = 0; n_re[i] = 0; n_im[i] = 0;
         end
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_OP_MODE:  mode  <= csr.data[1:0];
               CSR_ROWS_A:   ra    <= csr.data[3:0];
               CSR_COLS_A:   ca    <= csr.data[3:0];
               CSR_ROWS_B:   rb    <= csr.data[3:0];
               CSR_COLS_B:   cb    <= csr.data[3:0];
               CSR_EXPONENT: power <= csr.data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.command)
               CMD_LOAD_A: begin
                  a_re[req.row*8+req.col] = longint'(req.value_re);
                  a_im[req.row*8+req.col] = longint'(req.value_im);
               end
               CMD_LOAD_B: begin
                  b_re[req.row*8+req.col] = longint'(req.value_re);
                  b_im[req.row*8+req.col] = longint'(req.value_im);
               end
               CMD_START: begin
                  start_count++;
                  predict_run();
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (due_elems.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result item row %0d col %0d", $time,
                        rsp.out_row, rsp.out_col);
            end else begin
               want = due_elems.pop_front();
               if (rsp.out_row !== want.row || rsp.out_col !== want.col ||
                   rsp.result_re !== want.re || rsp.result_im !== want.im ||
                   rsp.size_error !== want.err || rsp.overflow !== want.ovf ||
                   rsp.last !== want.last) begin
                  fail_count++;
                  $display("%0t: mismatch expected r%0d c%0d %h %h err%0b ovf%0b last%0b",
                           $time, want.row, want.col, want.re, want.im, want.err,
                           want.ovf, want.last);
                  $display("%0t:            actual r%0d c%0d %h %h err%0b ovf%0b last%0b",
                           $time, rsp.out_row, rsp.out_col, rsp.result_re,
                           rsp.result_im, rsp.size_error, rsp.overflow, rsp.last);
               end
            end
         end
      end
   end
endmodule

// ===== tb/complex_matrix_arith_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the complex matrix engine testbench: clock, reset, stimulus and verdict.
// Depends on cmae_pkg, the channel interfaces, the engine core and cmae_checker.
module complex_matrix_arith_engine_core_tb;
   import cmae_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   // Command code that the engine does not define.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;

   cmae_req_if req ();
   cmae_rsp_if rsp ();
   cmae_csr_if csr ();

   int fail_count, pending, result_count, start_count;
   int cycles = 0;
   int item_count = 0;
   int hold_left = 0;
   int hold_req = 0;
   int hold_seen = 0;
   // When set, neither side inserts idle cycles.
   bit quiet = 0;
   // Tracks which store entries have been loaded, so no start reads an unwritten one.
   bit loaded_a[64];
   bit loaded_b[64];

   complex_matrix_arith_engine_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   cmae_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr          (csr),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count),
      .start_count  (start_count)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // The run is cut off if the engine ever hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result receiver. It stalls at random, except in quiet phases, and on request it
   // holds off for a long stretch so that the engine backs up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready = 0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 400;
         rsp.ready = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready = 0;
      end else begin
         rsp.ready = quiet || ($urandom_range(99) >= 17);
      end
   end

   // Offer one item on the input channel and wait until the engine takes it. Called
   // and returning at a falling edge.
   task automatic put_item(logic [1:0] cmd, int r, int c, logic [31:0] re, logic [31:0] im);
      if (!quiet && $urandom_range(99) < 17) begin
         req.valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.valid = 1;
      req.command = cmd;
      req.row = IDX_W'(r);
      req.col = IDX_W'(c);
      req.value_re = re;
      req.value_im = im;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      req.valid = 0;
      item_count++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      csr.valid = 1;
      csr.index = idx;
      csr.data = value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid = 0;
   endtask

   // Value kinds: 0 small numbers near unity, 1 any bits, 2 extremes, zero, all ones, unity.
   function automatic logic [31:0] pick_part(int kind);
      case (kind)
         0: return 32'(int'($urandom_range(0, 262144)) - 131072);
         1: return $urandom;
         default: begin
            case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   // Load a region of one store; unwritten entries always, the rest only sometimes.
   task automatic fill_region(bit to_b, int rows, int cols, int kind);
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            if (!(to_b ? loaded_b[i*8+j] : loaded_a[i*8+j]) || $urandom_range(1) == 1) begin
               put_item(to_b ? CMD_LOAD_B : CMD_LOAD_A, i, j, pick_part(kind),
                        pick_part(kind));
               if (to_b) loaded_b[i*8+j] = 1;
               else loaded_a[i*8+j] = 1;
            end
         end
      end
   endtask

   // One phase: wait until the engine is idle, write every register, load what the
   // operation reads, then start it.
   task automatic run_phase(logic [1:0] m, int ra, int ca, int rb, int cb, int ex,
                            int kind, bit press);
      bit good;
      while (pending != 0) @(negedge clock);
      // The engine may still be clearing its last element out after the final item.
      repeat (20) @(negedge clock);
      write_reg(CSR_OP_MODE, 8'(m));
      write_reg(CSR_ROWS_A, 8'(ra));
      write_reg(CSR_COLS_A, 8'(ca));
      write_reg(CSR_ROWS_B, 8'(rb));
      write_reg(CSR_COLS_B, 8'(cb));
      write_reg(CSR_EXPONENT, 8'(ex));
      if (m == MODE_ADD || m == MODE_SUB) begin
         good = ra >= 1 && ra <= 8 && ca >= 1 && ca <= 8 && ra == rb && ca == cb;
         if (good) begin
            fill_region(0, ra, ca, kind);
            fill_region(1, ra, ca, kind);
         end
      end else if (m == MODE_MUL) begin
         good = ra >= 1 && ra <= 8 && ca >= 1 && ca <= 8 && cb >= 1 && cb <= 8 && ca == rb;
         if (good) begin
            fill_region(0, ra, ca, kind);
            fill_region(1, rb, cb, kind);
         end
      end else begin
         good = ra >= 1 && ra <= 8 && ra == ca;
         if (good && ex != 0) fill_region(0, ra, ra, kind);
      end
      // An unknown command now and then; the engine must ignore it.
      if ($urandom_range(5) == 0) put_item(CMD_UNUSED, $urandom_range(7), $urandom_range(7),
                                           $urandom, $urandom);
      if (press) hold_req++;
      put_item(CMD_START, 0, 0, 0, 0);
      // With the receiver held off, these loads queue up behind the running start.
      if (press) begin
         for (int n = 0; n < 4; n++) begin
            put_item(CMD_LOAD_B, n, n, pick_part(0), pick_part(0));
            loaded_b[n*9] = 1;
         end
      end
   endtask

   initial begin
      int ra, ca, rb, cb, ex, sz, phase_no;
      logic [1:0] m;
      req.valid = 0; req.command = CMD_LOAD_A; req.row = 0; req.col = 0;
      req.value_re = 0; req.value_im = 0;
      csr.valid = 0; csr.index = CSR_OP_MODE; csr.data = 0;
      repeat (6) @(negedge clock);
      reset = 0;

      // Defaults after reset: 1x1 add, saturating the real part up and the imaginary down.
      put_item(CMD_LOAD_A, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      put_item(CMD_LOAD_B, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF);
      loaded_a[0] = 1; loaded_b[0] = 1;
      put_item(CMD_START, 0, 0, 0, 0);

      // Directed phases: each mode, identity and high powers, and each size error.
      run_phase(MODE_SUB, 2, 2, 2, 2, 0, 2, 0);
      run_phase(MODE_MUL, 2, 3, 3, 2, 0, 1, 0);
      run_phase(MODE_POW, 3, 3, 1, 1, 0, 0, 0);
      run_phase(MODE_POW, 2, 2, 1, 1, 1, 2, 0);
      run_phase(MODE_POW, 1, 1, 1, 1, 255, 0, 0);
      run_phase(MODE_ADD, 2, 2, 2, 3, 0, 0, 0);
      run_phase(MODE_MUL, 2, 3, 2, 2, 0, 0, 0);
      run_phase(MODE_POW, 2, 3, 1, 1, 2, 0, 0);
      run_phase(MODE_SUB, 0, 0, 0, 0, 0, 0, 0);
      run_phase(MODE_MUL, 1, 1, 1, 15, 0, 0, 0);
      run_phase(MODE_ADD, 9, 9, 9, 9, 0, 0, 0);

      // Random phases; the first covers the largest size and every index bit, and the
      // third runs a 3x3 add against a long receiver hold.
      phase_no = 0;
      while (item_count < 160) begin
         quiet = (phase_no % 5) == 3;
         if (phase_no == 0) begin
            run_phase(MODE_POW, 8, 8, 1, 1, 2, 1, 0);
         end else if (phase_no == 2) begin
            run_phase(MODE_ADD, 3, 3, 3, 3, 0, 0, 1);
         end else begin
            m = 2'($urandom_range(3));
            sz = ($urandom_range(9) == 0) ? 8 : 1;
            ra = (sz == 8) ? 8 : $urandom_range(1, 3);
            ca = (sz == 8) ? 8 : $urandom_range(1, 3);
            if (m == MODE_POW) ca = ra;
            rb = (m == MODE_MUL) ? ca : ra;
            cb = (m == MODE_MUL) ? ((sz == 8) ? 8 : $urandom_range(1, 3)) : ca;
            if ($urandom_range(7) == 0) begin
               // A broken shape or a dimension outside its range.
               case ($urandom_range(2))
                  0: ca = 0;
                  1: ra = $urandom_range(9, 15);
                  default: begin
                     rb = ra + 1;
                     ca = ra + 1;
                  end
               endcase
            end
            if (ra <= 2) ex = ($urandom_range(3) == 0) ? 255 : $urandom_range(0, 8);
            else ex = $urandom_range(0, 4);
            run_phase(m, ra, ca, rb, cb, ex,
                      (m == MODE_POW) ? 0 : $urandom_range(2), 0);
         end
         phase_no++;
      end

      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Ran %0d input items with %0d starts; %0d result items checked.",
               item_count, start_count, result_count);
      $display("Covered add, subtract, multiply, powers up to 255, size errors, stalls.");
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
